@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define VMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define VMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/vmc_pkg.sv @@
// shared types, constants and the square root step of the colour map pipeline
package vmc_pkg;

  localparam int SQUARE_STAGES   = 2;
  localparam int SQRT_STAGES     = 8;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SHADE_STAGES    = 2;
  localparam int PIPE_DEPTH      = SQUARE_STAGES + SQRT_STAGES + SHADE_STAGES;

  localparam logic [15:0] REF_SPEED_RESET = 16'd26;
  localparam logic [15:0] INV_RANGE_RESET = 16'd256;

  // register indexes of the configuration port
  localparam logic REG_REF_SPEED = 1'b0;
  localparam logic REG_INV_RANGE = 1'b1;

  // t in Q.8: one is 256
  localparam logic signed [9:0] T_ONE     = 10'sd256;
  localparam logic signed [9:0] T_NEG_ONE = -10'sd256;
  localparam logic [7:0]        FULL      = 8'd255;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
  } coord_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
  } sqrt_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  // one digit of the restoring square root: two radicand bits in, one root bit out
  function automatic sqrt_t sqrt_step(input sqrt_t cur);
    logic [18:0] r;
    logic [18:0] trial;
    sqrt_t       nxt;
    r        = {cur.rem, cur.rad[31:30]};
    trial    = {1'b0, cur.root, 2'b01};
    nxt.rad  = {cur.rad[29:0], 2'b00};
    if (r >= trial) begin
      nxt.rem  = 17'(r - trial);
      nxt.root = {cur.root[14:0], 1'b1};
    end else begin
      nxt.rem  = r[16:0];
      nxt.root = {cur.root[14:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

@@ hw/rtl/vmc_square.sv @@
// squares of the velocity pair and their sum, two register stages
module vmc_square (
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  output logic [31:0]        sum
);
  import vmc_pkg::*;

  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic [31:0]        sq_x;
  logic [31:0]        sq_y;

  assign prod_x = vel_x * vel_x;
  assign prod_y = vel_y * vel_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_x <= unsigned'(prod_x);
      sq_y <= unsigned'(prod_y);
    end
    // at most 2^31, no carry out
    if (en[1]) begin
      sum <= sq_x + sq_y;
    end
  end

endmodule

@@ hw/rtl/vmc_sqrt_stage.sv @@
// one register stage of the pipelined square root, two root bits per stage
module vmc_sqrt_stage (
  input  logic           clk,
  input  logic           en,
  input  vmc_pkg::sqrt_t d,
  output vmc_pkg::sqrt_t q
);
  import vmc_pkg::*;

  sqrt_t q_next;

  always_comb begin
    q_next = d;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      q_next = sqrt_step(q_next);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ hw/rtl/vmc_shade.sv @@
// speed offset and scale, then clamp of t and blue-white-red lookup
module vmc_shade (
  input  logic              clk,
  input  logic [1:0]        en,
  input  logic [15:0]       speed,
  input  logic [15:0]       ref_speed,
  input  logic [15:0]       inv_range,
  output vmc_pkg::colour_t  colour
);
  import vmc_pkg::*;

  logic signed [17:0] diff;
  logic signed [16:0] inv_s;
  logic signed [34:0] prod_next;
  logic signed [34:0] prod;
  logic signed [26:0] t_wide;
  logic signed [9:0]  t;
  logic [8:0]         s;
  logic [16:0]        scaled;
  logic [7:0]         ramp;
  colour_t            colour_next;

  assign diff      = signed'({2'b00, speed}) - signed'({2'b00, ref_speed});
  assign inv_s     = signed'({1'b0, inv_range});
  assign prod_next = diff * inv_s;

  always_comb begin
    // arithmetic shift by 8 floors toward minus infinity
    t_wide = prod[34:8];
    if (t_wide < 27'(T_NEG_ONE)) begin
      t = T_NEG_ONE;
    end else if (t_wide > 27'(T_ONE)) begin
      t = T_ONE;
    end else begin
      t = t_wide[9:0];
    end
    if (t < 10'sd0) begin
      s = 9'(t + T_ONE);
    end else begin
      s = 9'(T_ONE - t);
    end
    // 255 * s / 256 as (256 s - s) >> 8
    scaled = {s, 8'b0} - {8'b0, s};
    ramp   = scaled[15:8];
    if (t < 10'sd0) begin
      colour_next = '{red: ramp, green: ramp, blue: FULL};
    end else begin
      colour_next = '{red: FULL, green: ramp, blue: ramp};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= prod_next;
    end
    if (en[1]) begin
      colour <= colour_next;
    end
  end

endmodule

@@ hw/rtl/velocity_magnitude_colormap_top.sv @@
// top level of the velocity magnitude blue-white-red colour map pipeline
`include "assert_macros.svh"

// Maps one grid cell's signed Q8.8 velocity pair to a colour, one cell per
// clock while out_ready holds. Each transfer runs through a twelve-stage
// pipeline: two stages square and add the components, eight stages take the
// integer square root two root bits at a time, one stage offsets the speed by
// reference_speed and scales it by inv_velocity_range in an 18 by 17 bit
// multiplier, and the last stage clamps t to [-1, 1] and forms the colour in
// the output register. Every stage holds its item while the next is full, so
// in_ready stays high as long as any stage has a bubble. The coordinates ride
// alongside unchanged. Configuration writes take effect at once and should
// only be made while the pipeline is empty.
module velocity_magnitude_colormap_top (
  input  logic               clk,
  input  logic               rst,
  // input cells
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic [9:0]         pixel_x,
  input  logic [9:0]         pixel_y,
  // coloured cells
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [9:0]         out_x,
  output logic [9:0]         out_y,
  // configuration writes
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wr_data
);
  import vmc_pkg::*;

  // configuration registers
  logic [15:0] ref_speed;
  logic [15:0] inv_range;

  // per-stage valid bits and load enables
  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH-1:0] en;

  // coordinates travelling with each stage
  coord_t coord [PIPE_DEPTH];

  logic [31:0] sum;
  sqrt_t       sq_pipe [SQRT_STAGES+1];
  colour_t     colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_speed <= REF_SPEED_RESET;
      inv_range <= INV_RANGE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_REF_SPEED: ref_speed <= cfg_wr_data;
        REG_INV_RANGE: inv_range <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its successor loads this cycle
  always_comb begin
    en[PIPE_DEPTH-1] = !v[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      coord[0] <= '{x: pixel_x, y: pixel_y};
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (en[k]) begin
        coord[k] <= coord[k-1];
      end
    end
  end

  // squares and sum
  vmc_square u_square (
    .clk   (clk),
    .en    (en[SQUARE_STAGES-1:0]),
    .vel_x (vel_x),
    .vel_y (vel_y),
    .sum   (sum)
  );

  // square root, two bits of root per stage
  assign sq_pipe[0] = '{rem: '0, root: '0, rad: sum};

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    vmc_sqrt_stage u_stage (
      .clk (clk),
      .en  (en[SQUARE_STAGES+g]),
      .d   (sq_pipe[g]),
      .q   (sq_pipe[g+1])
    );
  end

  // offset, scale, clamp and colour
  vmc_shade u_shade (
    .clk       (clk),
    .en        (en[PIPE_DEPTH-1:PIPE_DEPTH-SHADE_STAGES]),
    .speed     (sq_pipe[SQRT_STAGES].root),
    .ref_speed (ref_speed),
    .inv_range (inv_range),
    .colour    (colour)
  );

  assign out_valid = v[PIPE_DEPTH-1];
  assign red       = colour.red;
  assign green     = colour.green;
  assign blue      = colour.blue;
  assign out_x     = coord[PIPE_DEPTH-1].x;
  assign out_y     = coord[PIPE_DEPTH-1].y;

  // an accepted transfer always lands in the first stage
  `VMC_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v[0], "accepted cell lost at entry")
  // with the last stage empty every stage can move, so input must be open
  `VMC_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input blocked with empty output")
  // diverging map: one of the two end channels is always saturated
  `VMC_ASSERT_NOW(a_colour_end, out_valid, red == FULL || blue == FULL, "colour off the map")
  // cold side keeps red and green equal
  `VMC_ASSERT_NOW(a_cold_grey, out_valid && red != FULL, red == green && blue == FULL,
                  "cold colour not on the blue ramp")

endmodule

@@ verif/colour_checker.sv @@
// checker that predicts the colour of every accepted cell and compares the results
module colour_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic [9:0]         pixel_x,
  input  logic [9:0]         pixel_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [9:0]         out_x,
  input  logic [9:0]         out_y,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wr_data,
  output int                 failures,
  output int                 cells_in_flight
);
  import vmc_pkg::*;

  typedef struct packed {
    colour_t shade;
    coord_t  pos;
  } coloured_cell_t;

  coloured_cell_t awaited_cells[$];
  coloured_cell_t next_cell;
  coloured_cell_t oldest_cell;
  logic [15:0]    white_speed;
  logic [15:0]    span_recip;

  initial begin
    failures        = 0;
    cells_in_flight = 0;
    white_speed     = REF_SPEED_RESET;
    span_recip      = INV_RANGE_RESET;
  end

  // speed by bitwise integer square root, then offset, scale, clamp and shade
  function automatic colour_t colour_of_velocity(input logic signed [15:0] vx,
                                                 input logic signed [15:0] vy);
    longint     sq_sum;
    longint     root;
    longint     trial;
    longint     offset;
    longint     t;
    logic [7:0] level;
    colour_t    c;
    sq_sum = longint'(vx) * longint'(vx) + longint'(vy) * longint'(vy);
    root   = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'sd1 << b);
      if (trial * trial <= sq_sum) root = trial;
    end
    offset = root - longint'(white_speed);
    t      = (offset * longint'(span_recip)) >>> 8;
    if (t < longint'(T_NEG_ONE)) t = longint'(T_NEG_ONE);
    if (t > longint'(T_ONE)) t = longint'(T_ONE);
    if (t < 0) begin
      level   = 8'((255 * (t + 256)) >>> 8);
      c.red   = level;
      c.green = level;
      c.blue  = FULL;
    end else begin
      level   = 8'((255 * (256 - t)) >>> 8);
      c.red   = FULL;
      c.green = level;
      c.blue  = level;
    end
    return c;
  endfunction

  task automatic report_failure(input string what);
    $display("mismatch: %s", what);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [9:0] got,
                             input logic [9:0] want);
    if (got !== want)
      report_failure($sformatf("%s of cell (%0d,%0d): got %0d, expected %0d",
                               name, oldest_cell.pos.x, oldest_cell.pos.y, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      white_speed = REF_SPEED_RESET;
      span_recip  = INV_RANGE_RESET;
      awaited_cells.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_REF_SPEED: white_speed = cfg_wr_data;
          REG_INV_RANGE: span_recip  = cfg_wr_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_cells.size() == 0) begin
          report_failure($sformatf("result for cell (%0d,%0d) with none awaited",
                                   out_x, out_y));
        end else begin
          oldest_cell = awaited_cells.pop_front();
          check_field("red", red, oldest_cell.shade.red);
          check_field("green", green, oldest_cell.shade.green);
          check_field("blue", blue, oldest_cell.shade.blue);
          check_field("out_x", out_x, oldest_cell.pos.x);
          check_field("out_y", out_y, oldest_cell.pos.y);
        end
      end
      if (in_valid && in_ready) begin
        next_cell.shade = colour_of_velocity(vel_x, vel_y);
        next_cell.pos.x = pixel_x;
        next_cell.pos.y = pixel_y;
        awaited_cells.push_back(next_cell);
      end
    end
    cells_in_flight <= awaited_cells.size();
  end

endmodule

@@ verif/tb.sv @@
// testbench top: stimulus, flow control and verdict for the colour map pipeline
module tb;
  import vmc_pkg::*;

  // cycles with no transfer on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic [9:0]         pixel_x;
  logic [9:0]         pixel_y;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [9:0]         out_x;
  logic [9:0]         out_y;
  logic               cfg_wr_en;
  logic               cfg_index;
  logic [15:0]        cfg_wr_data;

  int failures;
  int cells_in_flight;
  int idle_cycles;
  int burst_left;
  int white_now;

  // colour scale plan after the phase on reset values: zero range first,
  // then the corners of both registers, then something in between
  logic [15:0] white_plan [7] = '{16'd300, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1000,
                                  16'd26};
  logic [15:0] span_plan  [7] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd40,
                                  16'd256};

  velocity_magnitude_colormap_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_x       (out_x),
    .out_y       (out_y),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  colour_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .vel_x           (vel_x),
    .vel_y           (vel_y),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .out_x           (out_x),
    .out_y           (out_y),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .failures        (failures),
    .cells_in_flight (cells_in_flight)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[velocity_magnitude_colormap_top] ERROR");
        $finish;
      end
    end
  end

  // receiver: runs of always ready, coin toss, mostly ready and mostly stalled,
  // plus one long hold-off while cells are still offered so the pipe backs up
  initial begin
    int  mode;
    int  mode_left;
    int  cycle_count;
    bit  held;
    out_ready   = 1'b0;
    mode        = 0;
    mode_left   = 0;
    cycle_count = 0;
    held        = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst) begin
        cycle_count++;
        if (!held && cycle_count >= 900 && in_valid) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (100) @(negedge clk);
        end else begin
          if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
          end
          mode_left--;
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // hold valid low for a number of falling edges
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // offer one cell and wait for its transfer; bursts of random length
  // are broken up by random gaps, sometimes none at all
  task automatic offer_cell(input logic signed [15:0] vx, input logic signed [15:0] vy,
                            input logic [9:0] px, input logic [9:0] py);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    vel_x    <= vx;
    vel_y    <= vy;
    pixel_x  <= px;
    pixel_y  <= py;
    do @(posedge clk); while (!in_ready);
  endtask

  // velocities mixed: one case in four lands in the shaded band around the
  // white speed, with full range and diagonal cells for saturation and carries
  task automatic offer_random_cell();
    int mag;
    int vx_i;
    int vy_i;
    case ($urandom_range(0, 3))
      0: begin
        vx_i = int'($urandom_range(0, 65535)) - 32768;
        vy_i = int'($urandom_range(0, 65535)) - 32768;
      end
      1: begin
        vx_i = int'($urandom_range(0, 2048)) - 1024;
        vy_i = int'($urandom_range(0, 2048)) - 1024;
      end
      2: begin
        mag = white_now + int'($urandom_range(0, 600)) - 300;
        if (mag < 0) mag = 0;
        if (mag > 32767) mag = 32767;
        vx_i = $urandom_range(0, 1) ? mag : -mag;
        vy_i = int'($urandom_range(0, 64)) - 32;
      end
      default: begin
        mag  = $urandom_range(0, 32767);
        vx_i = $urandom_range(0, 1) ? mag : -mag;
        vy_i = $urandom_range(0, 1) ? mag : -mag;
      end
    endcase
    offer_cell(16'(vx_i), 16'(vy_i), 10'($urandom_range(0, 1023)),
               10'($urandom_range(0, 1023)));
  endtask

  // drop valid and wait at a falling edge until every cell has come back
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_in_flight != 0) @(negedge clk);
  endtask

  // both registers on consecutive edges; called at a falling edge, pipe empty
  task automatic set_colour_scale(input logic [15:0] white, input logic [15:0] span);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_REF_SPEED;
    cfg_wr_data <= white;
    @(negedge clk);
    cfg_index   <= REG_INV_RANGE;
    cfg_wr_data <= span;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    white_now = white;
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    vel_x       = '0;
    vel_y       = '0;
    pixel_x     = '0;
    pixel_y     = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_REF_SPEED;
    cfg_wr_data = '0;
    burst_left  = 0;
    white_now   = REF_SPEED_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed cells on the reset scale (white at 26, one unit per unit)
    offer_cell(16'sd0, 16'sd0, 10'd0, 10'd0);               // still cell, light blue
    offer_cell(16'sd26, 16'sd0, 10'd1023, 10'd1023);        // exactly white
    offer_cell(-16'sd26, 16'sd0, 10'h155, 10'h2AA);         // white from the negative side
    offer_cell(16'sd0, 16'sd26, 10'h2AA, 10'h155);
    offer_cell(16'sd25, 16'sd0, 10'd1, 10'd512);            // one step below white
    offer_cell(16'sd27, 16'sd0, 10'd512, 10'd1);            // one step above white
    offer_cell(16'sd282, 16'sd0, 10'd3, 10'd7);             // t lands on plus one
    offer_cell(16'sd283, 16'sd0, 10'd7, 10'd3);             // just past the clamp
    offer_cell(-16'sd32768, -16'sd32768, 10'd1023, 10'd0);  // largest sum of squares
    offer_cell(16'sd32767, 16'sd32767, 10'd0, 10'd1023);
    offer_cell(16'sd32767, -16'sd32768, 10'd100, 10'd900);
    offer_cell(-16'sd32768, 16'sd0, 10'd900, 10'd100);
    offer_cell(16'sd0, 16'sd32767, 10'd256, 10'd768);
    offer_cell(-16'sd1, -16'sd1, 10'd768, 10'd256);
    offer_cell(16'sd1, 16'sd0, 10'd2, 10'd2);
    offer_cell(16'sd3, 16'sd4, 10'd5, 10'd5);               // perfect square root
    offer_random_cell();
    repeat (190) offer_random_cell();

    // walk through the colour scale plan, then two random scales
    for (int p = 0; p < 9; p++) begin
      drain_pipeline();
      if (p < 7) set_colour_scale(white_plan[p], span_plan[p]);
      else set_colour_scale(16'($urandom_range(0, 12000)), 16'($urandom_range(1, 2048)));
      if (p == 0) begin
        // zero range register: every speed shades to white
        offer_cell(16'sd0, 16'sd0, 10'd0, 10'd1023);
        offer_cell(-16'sd32768, -16'sd32768, 10'd1023, 10'd0);
        offer_cell(16'sd300, 16'sd0, 10'd512, 10'd512);
      end
      repeat (170) offer_random_cell();
    end

    drain_pipeline();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (failures == 0) begin
      $display("[velocity_magnitude_colormap_top] OK");
    end else begin
      $display("[velocity_magnitude_colormap_top] ERROR");
    end
    $finish;
  end

endmodule
